/* rtl/nbg_pkg.sv */
package nbg_pkg;

  localparam int unsigned AccW  = 64;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned MassW = 31;
  localparam int unsigned IoW   = 32;

  localparam logic [1:0] CfgGravity = 2'd0;
  localparam logic [1:0] CfgDelta   = 2'd1;
  localparam logic [1:0] CfgCount   = 2'd2;
  localparam logic [1:0] CfgMinDist = 2'd3;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqStep = 1'b1;

  localparam logic [3:0] StepDistSq  = 4'd2;
  localparam logic [3:0] StepLastAdv = 4'd1;
  localparam logic [3:0] StepLastCal = 4'd15;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CAP_B,
    S_CALC,
    S_WR_A,
    S_WR_B,
    S_NEXT,
    S_RD_E,
    S_CAP_E,
    S_ADV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    alu_op_e         op;
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

/* rtl/nbg_alu.sv */
module nbg_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nbg_pkg::alu_req_t            req_i,
  output nbg_pkg::alu_rsp_t            rsp_o,
  output logic [nbg_pkg::AccW-1:0]     res_o
);
  import nbg_pkg::*;

  localparam logic [AccW-1:0] SqrtTop = AccW'(1) << (AccW - 2);

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  alu_op_e         op_q;
  logic            ovf_q, ovf_d;
  logic [AccW-1:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d;
  logic [AccW:0]   sum, rem2, trial;
  logic [5:0]      last_cnt;
  logic            launch;

  assign launch   = req_i.start && !busy_q;
  assign last_cnt = (op_q == OP_SQRT) ? 6'd31 : 6'd63;

  always_comb begin
    r0_d  = r0_q;
    r1_d  = r1_q;
    r2_d  = r2_q;
    ovf_d = ovf_q;
    sum   = '0;
    rem2  = '0;
    trial = '0;
    case (op_q)
      OP_MUL: begin
        sum   = {1'b0, r0_q[AccW-2:0], 1'b0} +
                {1'b0, (r1_q[AccW-1] ? r2_q : {AccW{1'b0}})};
        ovf_d = ovf_q | r0_q[AccW-1] | sum[AccW];
        r0_d  = sum[AccW-1:0];
        r1_d  = {r1_q[AccW-2:0], 1'b0};
      end
      OP_DIV: begin
        rem2 = {r0_q, r1_q[AccW-1]};
        if (rem2 >= {1'b0, r2_q}) begin
          trial = rem2 - {1'b0, r2_q};
          r0_d  = trial[AccW-1:0];
          r1_d  = {r1_q[AccW-2:0], 1'b1};
        end else begin
          r0_d = rem2[AccW-1:0];
          r1_d = {r1_q[AccW-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        trial = {1'b0, r1_q} + {1'b0, r2_q};
        if ({1'b0, r0_q} >= trial) begin
          r0_d = r0_q - trial[AccW-1:0];
          r1_d = (r1_q >> 1) + r2_q;
        end else begin
          r1_d = r1_q >> 1;
        end
        r2_d = r2_q >> 2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (launch) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      op_q  <= req_i.op;
      ovf_q <= 1'b0;
      case (req_i.op)
        OP_MUL: begin
          r0_q <= '0;
          r1_q <= req_i.b;
          r2_q <= req_i.a;
        end
        OP_DIV: begin
          r0_q <= '0;
          r1_q <= req_i.a;
          r2_q <= req_i.b;
        end
        default: begin
          r0_q <= req_i.a;
          r1_q <= '0;
          r2_q <= SqrtTop;
        end
      endcase
    end else if (busy_q) begin
      ovf_q <= ovf_d;
      r0_q  <= r0_d;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = ovf_q ? '1 : r0_q;
      default: res_o = r1_q;
    endcase
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

/* rtl/nbg_store.sv */
module nbg_store #(
  parameter int unsigned Width = 159,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/nbody_gravity_step_2d.sv */
// Two-dimensional direct-summation gravity engine for up to NUM_BODIES bodies.
// Input channel: a load item writes one body (position, velocity, mass) in
// the cycle of its transfer and produces no result. A step item runs every
// unordered pair of the first body_count bodies, then advances positions and
// emits one result per body in index order, with last_body on the final one.
// Multiplies, divides and square roots all go through one shared multicycle unit,
// which takes a new operation only when idle; its 64-bit multiply saturates. A
// pair that is too close to exert force is skipped after the square root, with
// no velocity change. The input is stalled from the transfer of a step item with
// a nonzero body count until its last result is loaded into the output register.
// Results wait in that register while the receiver stalls, and the engine waits
// with them. Configuration writes are taken at any cycle the write enable is
// high. Reset restores the register defaults and empties the output register;
// body storage is not cleared.
module nbody_gravity_step_2d #(
  parameter int unsigned NUM_BODIES    = 64,
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [nbg_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [5:0]                    body_index_i,
  input  logic signed [nbg_pkg::IoW-1:0] load_pos_x_i,
  input  logic signed [nbg_pkg::IoW-1:0] load_pos_y_i,
  input  logic signed [nbg_pkg::IoW-1:0] load_vel_x_i,
  input  logic signed [nbg_pkg::IoW-1:0] load_vel_y_i,
  input  logic [nbg_pkg::MassW-1:0]     load_mass_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    out_index_o,
  output logic signed [nbg_pkg::IoW-1:0] out_pos_x_o,
  output logic signed [nbg_pkg::IoW-1:0] out_pos_y_o,
  output logic signed [nbg_pkg::IoW-1:0] out_vel_x_o,
  output logic signed [nbg_pkg::IoW-1:0] out_vel_y_o,
  output logic                          last_body_o
);
  import nbg_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned IdxW  = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam int unsigned RecW  = 4 * W + MassW;
  localparam int unsigned ExtW  = AccW + 2;
  localparam logic [AccW-1:0] One      = AccW'(1) << FRACTION_BITS;
  localparam logic [AccW-1:0] DeltaCap = AccW'(1) << (AccW - 2);
  localparam logic signed [ExtW-1:0] WordMax = (ExtW'(1) <<< (W - 1)) - ExtW'(1);
  localparam logic signed [ExtW-1:0] WordMin = -WordMax - ExtW'(1);
  localparam logic [CntW-1:0] NumBodies = CntW'(NUM_BODIES);

  function automatic logic signed [W-1:0] clamp_word(input logic signed [ExtW-1:0] s);
    logic signed [W-1:0] r;
    if (s > WordMax) begin
      r = WordMax[W-1:0];
    end else if (s < WordMin) begin
      r = WordMin[W-1:0];
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ExtW-1:0] ext_word(input logic signed [W-1:0] v);
    return {{(ExtW - W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] apply_delta(input logic signed [W-1:0] v,
                                                      input logic [AccW-1:0] mag,
                                                      input logic neg);
    logic [AccW-1:0]        m;
    logic signed [ExtW-1:0] ms, s;
    m  = (mag > DeltaCap) ? DeltaCap : mag;
    ms = {2'b00, m};
    s  = neg ? ext_word(v) - ms : ext_word(v) + ms;
    return clamp_word(s);
  endfunction

  function automatic logic [AccW-1:0] mag_word(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v[W-1] ? W'(-v) : W'(v);
    return AccW'(u);
  endfunction

  function automatic logic signed [W-1:0] load_word(input logic signed [IoW-1:0] v);
    logic signed [ExtW-1:0] e;
    e = {{(ExtW - IoW){v[IoW-1]}}, v};
    return clamp_word(e);
  endfunction

  function automatic logic [IoW-1:0] out_word(input logic signed [W-1:0] v);
    logic signed [ExtW-1:0] e;
    e = ext_word(v);
    return e[IoW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [CfgW-1:0] grav_q, delta_q, mind_q;
  logic [CntW-1:0] bcnt_q;

  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, e_q, e_d, cnt_calc;
  logic [3:0]      mstep_q, mstep_d;
  logic            issued_q, issued_d;

  logic signed [W-1:0] pxa_q, pxa_d, pya_q, pya_d, vxa_q, vxa_d, vya_q, vya_d;
  logic signed [W-1:0] pxb_q, pxb_d, pyb_q, pyb_d, vxb_q, vxb_d, vyb_q, vyb_d;
  logic [MassW-1:0]    ma_q, ma_d, mb_q, mb_d;
  logic [AccW-1:0]     tmp_q, tmp_d, dsq48_q, dsq48_d, dist_q, dist_d;
  logic [AccW-1:0]     ux_q, ux_d, uy_q, uy_d, acca_q, acca_d, accb_q, accb_d;

  logic                out_valid_q, out_valid_d;
  logic [5:0]          oidx_q, oidx_d;
  logic [IoW-1:0]      opx_q, opx_d, opy_q, opy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic                olast_q, olast_d;

  logic                in_xfer, out_free, close;
  logic signed [W:0]   dx, dy;
  logic [W:0]          adx, ady;
  logic [AccW-1:0]     ax, ay, dsq, res_shift;
  logic                dx_pos, dx_neg, dy_pos, dy_neg;
  logic [AccW:0]       dsum;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic [AccW-1:0]     alu_res;

  logic                st_we;
  logic [IdxW-1:0]     st_waddr, st_raddr;
  logic [RecW-1:0]     st_wdata, st_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_calc   = (bcnt_q > NumBodies) ? NumBodies : bcnt_q;

  assign dx     = {pxa_q[W-1], pxa_q} - {pxb_q[W-1], pxb_q};
  assign dy     = {pya_q[W-1], pya_q} - {pyb_q[W-1], pyb_q};
  assign adx    = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
  assign ady    = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
  assign ax     = AccW'(adx);
  assign ay     = AccW'(ady);
  assign dx_neg = dx[W];
  assign dy_neg = dy[W];
  assign dx_pos = !dx[W] && (dx != '0);
  assign dy_pos = !dy[W] && (dy != '0);
  assign dsq    = dsq48_q >> FRACTION_BITS;
  assign res_shift = alu_res >> FRACTION_BITS;
  assign dsum   = {1'b0, tmp_q} + {1'b0, alu_res};
  assign close  = (dsq == '0) || (alu_res == '0) || (dsq < AccW'(mind_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= CfgW'(13589545);
      delta_q <= CfgW'(55924);
      bcnt_q  <= CntW'(2);
      mind_q  <= CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgGravity: grav_q  <= cfg_data_i;
        CfgDelta:   delta_q <= cfg_data_i;
        CfgCount:   bcnt_q  <= cfg_data_i[CntW-1:0];
        CfgMinDist: mind_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && req_type_i == ReqStep) begin
          if (cnt_calc >= CntW'(2)) begin
            state_d = S_RD_A;
          end else if (cnt_calc != '0) begin
            state_d = S_RD_E;
          end
        end
      end
      S_RD_A:  state_d = S_RD_B;
      S_RD_B:  state_d = S_CAP_B;
      S_CAP_B: state_d = S_CALC;
      S_CALC: begin
        if (alu_rsp.done) begin
          if (mstep_q == StepDistSq && close) begin
            state_d = S_NEXT;
          end else if (mstep_q == StepLastCal) begin
            state_d = S_WR_A;
          end
        end
      end
      S_WR_A: state_d = S_WR_B;
      S_WR_B: state_d = S_NEXT;
      S_NEXT: begin
        if (j_q + CntW'(1) < cnt_q || i_q + CntW'(2) < cnt_q) begin
          state_d = S_RD_A;
        end else begin
          state_d = S_RD_E;
        end
      end
      S_RD_E:  state_d = S_CAP_E;
      S_CAP_E: state_d = S_ADV;
      S_ADV: begin
        if (alu_rsp.done && mstep_q == StepLastAdv) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = (e_q + CntW'(1) == cnt_q) ? S_IDLE : S_RD_E;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; i_d = i_q; j_d = j_q; e_d = e_q;
    mstep_d = mstep_q; issued_d = issued_q;
    pxa_d = pxa_q; pya_d = pya_q; vxa_d = vxa_q; vya_d = vya_q; ma_d = ma_q;
    pxb_d = pxb_q; pyb_d = pyb_q; vxb_d = vxb_q; vyb_d = vyb_q; mb_d = mb_q;
    tmp_d = tmp_q; dsq48_d = dsq48_q; dist_d = dist_q;
    ux_d = ux_q; uy_d = uy_q; acca_d = acca_q; accb_d = accb_q;
    out_valid_d = out_valid_q && out_stall_i;
    oidx_d = oidx_q; opx_d = opx_q; opy_d = opy_q; ovx_d = ovx_q; ovy_d = ovy_q;
    olast_d = olast_q;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    st_we    = 1'b0;
    st_waddr = i_q[IdxW-1:0];
    st_wdata = {ma_q, vya_q, vxa_q, pya_q, pxa_q};
    st_raddr = i_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (req_type_i == ReqLoad) begin
            st_we    = ({1'b0, body_index_i} < NumBodies);
            st_waddr = body_index_i[IdxW-1:0];
            st_wdata = {load_mass_i, load_word(load_vel_y_i), load_word(load_vel_x_i),
                        load_word(load_pos_y_i), load_word(load_pos_x_i)};
          end else begin
            cnt_d = cnt_calc;
            i_d   = '0;
            j_d   = CntW'(1);
            e_d   = '0;
          end
        end
      end
      S_RD_A: begin
        st_raddr = i_q[IdxW-1:0];
      end
      S_RD_B: begin
        st_raddr = j_q[IdxW-1:0];
        pxa_d = st_rdata[W-1:0];
        pya_d = st_rdata[2*W-1:W];
        vxa_d = st_rdata[3*W-1:2*W];
        vya_d = st_rdata[4*W-1:3*W];
        ma_d  = st_rdata[RecW-1:4*W];
      end
      S_CAP_B, S_CAP_E: begin
        if (state_q == S_CAP_B) begin
          pxb_d = st_rdata[W-1:0];
          pyb_d = st_rdata[2*W-1:W];
          vxb_d = st_rdata[3*W-1:2*W];
          vyb_d = st_rdata[4*W-1:3*W];
          mb_d  = st_rdata[RecW-1:4*W];
        end else begin
          pxa_d = st_rdata[W-1:0];
          pya_d = st_rdata[2*W-1:W];
          vxa_d = st_rdata[3*W-1:2*W];
          vya_d = st_rdata[4*W-1:3*W];
          ma_d  = st_rdata[RecW-1:4*W];
        end
        mstep_d  = '0;
        issued_d = 1'b0;
      end
      S_CALC: begin
        alu_req.start = !issued_q;
        if (!issued_q) begin
          issued_d = 1'b1;
        end
        case (mstep_q)
          4'd0: begin alu_req.a = ax; alu_req.b = ax; end
          4'd1: begin alu_req.a = ay; alu_req.b = ay; end
          4'd2: begin alu_req.op = OP_SQRT; alu_req.a = dsq48_q; end
          4'd3: begin alu_req.a = ax; alu_req.b = One; end
          4'd4: begin alu_req.op = OP_DIV; alu_req.a = tmp_q; alu_req.b = dist_q; end
          4'd5: begin alu_req.a = ay; alu_req.b = One; end
          4'd6: begin alu_req.op = OP_DIV; alu_req.a = tmp_q; alu_req.b = dist_q; end
          4'd7: begin alu_req.a = AccW'(delta_q); alu_req.b = AccW'(grav_q); end
          4'd8: begin alu_req.a = tmp_q; alu_req.b = One; end
          4'd9: begin alu_req.op = OP_DIV; alu_req.a = tmp_q; alu_req.b = dsq; end
          4'd10: begin alu_req.a = tmp_q; alu_req.b = AccW'(mb_q); end
          4'd11: begin alu_req.a = tmp_q; alu_req.b = AccW'(ma_q); end
          4'd12: begin alu_req.a = acca_q; alu_req.b = ux_q; end
          4'd13: begin alu_req.a = acca_q; alu_req.b = uy_q; end
          4'd14: begin alu_req.a = accb_q; alu_req.b = ux_q; end
          default: begin alu_req.a = accb_q; alu_req.b = uy_q; end
        endcase
        if (alu_rsp.done) begin
          issued_d = 1'b0;
          mstep_d  = mstep_q + 4'd1;
          case (mstep_q)
            4'd0: tmp_d = alu_res;
            4'd1: dsq48_d = dsum[AccW] ? '1 : dsum[AccW-1:0];
            4'd2: dist_d = alu_res;
            4'd3, 4'd5, 4'd8: tmp_d = alu_res;
            4'd4: ux_d = alu_res;
            4'd6: uy_d = alu_res;
            4'd7: tmp_d = res_shift;
            4'd9: tmp_d = alu_res;
            4'd10: acca_d = res_shift;
            4'd11: accb_d = res_shift;
            4'd12: vxa_d = apply_delta(vxa_q, res_shift, dx_pos);
            4'd13: vya_d = apply_delta(vya_q, res_shift, dy_pos);
            4'd14: vxb_d = apply_delta(vxb_q, res_shift, dx_neg);
            default: vyb_d = apply_delta(vyb_q, res_shift, dy_neg);
          endcase
        end
      end
      S_WR_A: begin
        st_we = 1'b1;
      end
      S_WR_B: begin
        st_we    = 1'b1;
        st_waddr = j_q[IdxW-1:0];
        st_wdata = {mb_q, vyb_q, vxb_q, pyb_q, pxb_q};
      end
      S_NEXT: begin
        if (j_q + CntW'(1) < cnt_q) begin
          j_d = j_q + CntW'(1);
        end else begin
          i_d = i_q + CntW'(1);
          j_d = i_q + CntW'(2);
        end
      end
      S_RD_E: begin
        st_raddr = e_q[IdxW-1:0];
      end
      S_ADV: begin
        alu_req.start = !issued_q;
        if (!issued_q) begin
          issued_d = 1'b1;
        end
        alu_req.a = (mstep_q == '0) ? mag_word(vxa_q) : mag_word(vya_q);
        alu_req.b = AccW'(delta_q);
        if (alu_rsp.done) begin
          issued_d = 1'b0;
          mstep_d  = mstep_q + 4'd1;
          if (mstep_q == '0) begin
            pxa_d = apply_delta(pxa_q, res_shift, vxa_q[W-1]);
          end else begin
            pya_d = apply_delta(pya_q, res_shift, vya_q[W-1]);
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          st_we       = 1'b1;
          st_waddr    = e_q[IdxW-1:0];
          out_valid_d = 1'b1;
          oidx_d      = e_q[5:0];
          opx_d       = out_word(pxa_q);
          opy_d       = out_word(pya_q);
          ovx_d       = out_word(vxa_q);
          ovy_d       = out_word(vya_q);
          olast_d     = (e_q + CntW'(1) == cnt_q);
          e_d         = e_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      issued_q    <= 1'b0;
      mstep_q     <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      e_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      issued_q    <= issued_d;
      mstep_q     <= mstep_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      e_q         <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pxa_q <= pxa_d; pya_q <= pya_d; vxa_q <= vxa_d; vya_q <= vya_d; ma_q <= ma_d;
    pxb_q <= pxb_d; pyb_q <= pyb_d; vxb_q <= vxb_d; vyb_q <= vyb_d; mb_q <= mb_d;
    tmp_q <= tmp_d; dsq48_q <= dsq48_d; dist_q <= dist_d;
    ux_q <= ux_d; uy_q <= uy_d; acca_q <= acca_d; accb_q <= accb_d;
    oidx_q <= oidx_d; opx_q <= opx_d; opy_q <= opy_d; ovx_q <= ovx_d; ovy_q <= ovy_d;
    olast_q <= olast_d;
  end

  nbg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  nbg_store #(
    .Width (RecW),
    .Depth (NUM_BODIES),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_index_o = oidx_q;
  assign out_pos_x_o = opx_q;
  assign out_pos_y_o = opy_q;
  assign out_vel_x_o = ovx_q;
  assign out_vel_y_o = ovy_q;
  assign last_body_o = olast_q;

  a_idle_alu_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !alu_rsp.busy)
    else $error("arithmetic unit busy while idle");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_CALC || state_q == S_ADV))
    else $error("arithmetic result outside a compute state");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result appeared outside the emit state");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we && state_q == S_IDLE |-> in_xfer && req_type_i == ReqLoad)
    else $error("store written while idle without a load");

endmodule
